// ===== sv/ntc_pkg.sv =====
// Shared types, constants and codes for the NTC trimmed-mean temperature block.
package ntc_pkg;

  localparam int SAMPLES_DEFAULT = 5;

  localparam int ADC_W  = 10;
  localparam int SUM_W  = 17;
  localparam int TEMP_W = 10;
  localparam int STAT_W = 2;
  localparam int CFG_W  = 20;
  localparam int BETA_W = 16;
  localparam int OHM_W  = 20;

  // Register indexes of the configuration port.
  localparam logic [1:0] CFG_BETA    = 2'd0;
  localparam logic [1:0] CFG_SERIES  = 2'd1;
  localparam logic [1:0] CFG_NOMINAL = 2'd2;

  localparam logic [BETA_W-1:0] BETA_RESET = 16'd3700;
  localparam logic [OHM_W-1:0]  OHMS_RESET = 20'd120000;

  // Status codes of a result.
  localparam logic [STAT_W-1:0] STATUS_NORMAL = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_LOW    = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_HIGH   = 2'd2;

  localparam logic [ADC_W-1:0]  ADC_FULL  = 10'd1023;
  localparam logic [TEMP_W-1:0] TEMP_MAX  = 10'd999;
  localparam logic [31:0]       LN2_Q32   = 32'd2977044472;
  localparam logic [15:0]       T0_CENTI  = 16'd29815;
  localparam logic [22:0]       B_SCALE   = 23'd6553600;
  localparam logic [23:0]       KQ8_MAX   = 24'hFFFFFF;

  // Serial divider geometry.
  localparam int DIV_REM_W  = 42;
  localparam int DIV_Q_W    = 24;
  localparam int DIV_STEP_W = 5;
  localparam logic [DIV_STEP_W-1:0] MEAN_STEPS   = 5'd17;
  localparam logic [DIV_STEP_W-1:0] KELVIN_STEPS = 5'd24;

  // Log unit geometry.
  localparam int LN_X_W   = 20;
  localparam int LN_OUT_W = 21;

  typedef struct packed {
    logic                  start;
    logic [DIV_STEP_W-1:0] steps;
    logic [DIV_REM_W-1:0]  rem_init;
    logic [DIV_Q_W-1:0]    dividend;
    logic [DIV_REM_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_Q_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [2:0] {
    LN_IDLE,
    LN_NORM,
    LN_SQ,
    LN_MUL,
    LN_DONE
  } ln_state_e;

  typedef enum logic [3:0] {
    ST_COLLECT,
    ST_TRIM,
    ST_MEAN,
    ST_CHECK,
    ST_LOG,
    ST_DEN1,
    ST_DEN2,
    ST_DEN3,
    ST_DEN4,
    ST_KDIV,
    ST_FIN,
    ST_EMIT
  } top_state_e;

endpackage

// ===== sv/ntc_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
module ntc_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ntc_pkg::div_req_t req_i,
  output ntc_pkg::div_rsp_t rsp_o
);

  logic [ntc_pkg::DIV_REM_W-1:0]  rem_q, rem_d, rem_sh, dvs_q;
  logic [ntc_pkg::DIV_Q_W-1:0]    dvd_q, quo_q;
  logic [ntc_pkg::DIV_STEP_W-1:0] left_q;
  logic                           busy_q, done_q;
  logic                           fits;

  assign rem_sh = {rem_q[ntc_pkg::DIV_REM_W-2:0], dvd_q[ntc_pkg::DIV_Q_W-1]};
  assign fits   = (rem_sh >= dvs_q);
  assign rem_d  = fits ? (rem_sh - dvs_q) : rem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      left_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        left_q <= req_i.steps;
      end else if (busy_q) begin
        left_q <= left_q - 1'b1;
        if (left_q == ntc_pkg::DIV_STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.rem_init;
      dvd_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[ntc_pkg::DIV_Q_W-2:0], 1'b0};
      quo_q <= {quo_q[ntc_pkg::DIV_Q_W-2:0], fits};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ===== sv/ntc_ln.sv =====
// Iterative natural logarithm in Q16: leading-one search, squaring loop, scale by ln 2.
module ntc_ln (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [ntc_pkg::LN_X_W-1:0]   x_i,
  output logic                         done_o,
  output logic [ntc_pkg::LN_OUT_W-1:0] ln_o
);

  ntc_pkg::ln_state_e state_q, state_d;

  logic [ntc_pkg::LN_X_W-1:0]   x_q;
  logic [4:0]                   p_q;
  logic [30:0]                  y_q;
  logic [15:0]                  frac_q;
  logic [3:0]                   cnt_q;
  logic [ntc_pkg::LN_OUT_W-1:0] ln_q;
  logic [61:0]                  sq;
  logic [31:0]                  y2;
  logic [52:0]                  scaled;

  assign sq     = {31'd0, y_q} * {31'd0, y_q};
  assign y2     = sq[61:30];
  assign scaled = {32'd0, p_q, frac_q} * {21'd0, ntc_pkg::LN2_Q32} + 53'h0_0000_8000_0000;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ntc_pkg::LN_IDLE: if (start_i) state_d = ntc_pkg::LN_NORM;
      ntc_pkg::LN_NORM: if (x_q[ntc_pkg::LN_X_W-1]) state_d = ntc_pkg::LN_SQ;
      ntc_pkg::LN_SQ:   if (cnt_q == 4'd15) state_d = ntc_pkg::LN_MUL;
      ntc_pkg::LN_MUL:  state_d = ntc_pkg::LN_DONE;
      ntc_pkg::LN_DONE: if (start_i) state_d = ntc_pkg::LN_NORM;
      default:          state_d = ntc_pkg::LN_IDLE;
    endcase
  end

  always_comb begin
    done_o = (state_q == ntc_pkg::LN_DONE);
    ln_o   = ln_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ntc_pkg::LN_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ntc_pkg::LN_SQ) cnt_q <= cnt_q + 1'b1;
      else cnt_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ntc_pkg::LN_IDLE, ntc_pkg::LN_DONE: begin
        if (start_i) begin
          x_q    <= x_i;
          p_q    <= 5'(ntc_pkg::LN_X_W - 1);
          frac_q <= '0;
        end
      end
      ntc_pkg::LN_NORM: begin
        // Shift one place a cycle until the leading one sits at the top.
        if (!x_q[ntc_pkg::LN_X_W-1]) begin
          x_q <= {x_q[ntc_pkg::LN_X_W-2:0], 1'b0};
          p_q <= p_q - 1'b1;
        end else begin
          y_q <= {x_q, 11'd0};
        end
      end
      ntc_pkg::LN_SQ: begin
        frac_q <= {frac_q[14:0], y2[31]};
        y_q    <= y2[31] ? y2[31:1] : y2[30:0];
      end
      ntc_pkg::LN_MUL: ln_q <= scaled[52:32];
      default: ;
    endcase
  end

  a_ln_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ln_q[ntc_pkg::LN_OUT_W-1] == 1'b0)
    else $error("log result out of range");

endmodule

// ===== sv/ntc_trimmed_mean_temperature.sv =====
// Top level: sample collection, sequencing of the conversion and the result register.
// Samples are taken one per cycle while a group is being gathered. After the last sample
// of a group the block accepts no sample until the conversion has finished and its
// result has gone to the output register. A full conversion consists of starting the
// bit-serial divider, its 17 steps on the trimmed mean and the hand-over, a check, the
// four log units (a leading-one search, 16 squaring steps and the ln 2 scaling, all four
// side by side), the denominator arithmetic, the 24 steps of the same divider on the
// Kelvin quotient, rounding and loading the output register. A mean of zero or full
// scale skips the rest of the conversion; a nonpositive denominator or a saturated
// quotient skips the Kelvin division. A finished result waits in the output register
// while the next group is gathered, and the return to gathering waits until that
// register is free.
module ntc_trimmed_mean_temperature #(
  parameter int SamplesPerReading = ntc_pkg::SAMPLES_DEFAULT
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [ntc_pkg::CFG_W-1:0]  cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [ntc_pkg::ADC_W-1:0]  adc_sample_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [ntc_pkg::TEMP_W-1:0] temperature_c_o,
  output logic [ntc_pkg::ADC_W-1:0]  mean_adc_o,
  output logic [ntc_pkg::STAT_W-1:0] status_o
);

  localparam int CntW = $clog2(SamplesPerReading);

  ntc_pkg::top_state_e state_q, state_d;

  logic [ntc_pkg::BETA_W-1:0] beta_q;
  logic [ntc_pkg::OHM_W-1:0]  series_q, nominal_q;
  logic [ntc_pkg::BETA_W-1:0] beta_eff;
  logic [ntc_pkg::OHM_W-1:0]  series_eff, nominal_eff;

  logic [CntW-1:0]           cnt_q;
  logic [ntc_pkg::SUM_W-1:0] sum_q;
  logic [ntc_pkg::ADC_W-1:0] min_q, max_q, mean_q;
  logic                      in_acc, last_sample;

  ntc_pkg::div_req_t div_req;
  ntc_pkg::div_rsp_t div_rsp;

  logic [ntc_pkg::LN_X_W-1:0]   ln_x   [4];
  logic [ntc_pkg::LN_OUT_W-1:0] ln_res [4];
  logic [3:0]                   ln_done;
  logic                         ln_start;

  logic signed [22:0] l_q;
  logic [38:0]        bterm_q;
  logic signed [37:0] lterm_q;
  logic [30:0]        rem0_q;
  logic signed [40:0] den_q;
  logic [23:0]        k_q;
  logic signed [25:0] cq8;
  logic               den_pos, k_sat;

  logic [ntc_pkg::TEMP_W-1:0] res_temp_q, temp_q;
  logic [ntc_pkg::STAT_W-1:0] res_stat_q, stat_q;
  logic [ntc_pkg::ADC_W-1:0]  mean_out_q;
  logic                       out_valid_q, out_free;

  // Configuration registers; a zero value is treated as one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beta_q    <= ntc_pkg::BETA_RESET;
      series_q  <= ntc_pkg::OHMS_RESET;
      nominal_q <= ntc_pkg::OHMS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ntc_pkg::CFG_BETA:    beta_q    <= cfg_data_i[ntc_pkg::BETA_W-1:0];
        ntc_pkg::CFG_SERIES:  series_q  <= cfg_data_i;
        ntc_pkg::CFG_NOMINAL: nominal_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign beta_eff    = (beta_q == '0) ? ntc_pkg::BETA_W'(1) : beta_q;
  assign series_eff  = (series_q == '0) ? ntc_pkg::OHM_W'(1) : series_q;
  assign nominal_eff = (nominal_q == '0) ? ntc_pkg::OHM_W'(1) : nominal_q;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign last_sample = (cnt_q == CntW'(SamplesPerReading - 1));
  assign out_free    = !out_valid_q || !out_stall_i;

  assign den_pos = !den_q[40] && (den_q != '0);
  assign k_sat   = ({9'd0, rem0_q} >= den_q[39:0]);
  assign cq8     = $signed({2'b00, k_q}) + 26'sd128 - 26'sd69926;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ntc_pkg::ST_COLLECT: if (in_acc && last_sample) state_d = ntc_pkg::ST_TRIM;
      ntc_pkg::ST_TRIM:    state_d = ntc_pkg::ST_MEAN;
      ntc_pkg::ST_MEAN:    if (div_rsp.done) state_d = ntc_pkg::ST_CHECK;
      ntc_pkg::ST_CHECK: begin
        if (mean_q == '0 || mean_q == ntc_pkg::ADC_FULL) state_d = ntc_pkg::ST_EMIT;
        else state_d = ntc_pkg::ST_LOG;
      end
      ntc_pkg::ST_LOG:  if (&ln_done) state_d = ntc_pkg::ST_DEN1;
      ntc_pkg::ST_DEN1: state_d = ntc_pkg::ST_DEN2;
      ntc_pkg::ST_DEN2: state_d = ntc_pkg::ST_DEN3;
      ntc_pkg::ST_DEN3: state_d = ntc_pkg::ST_DEN4;
      ntc_pkg::ST_DEN4: begin
        if (!den_pos) state_d = ntc_pkg::ST_EMIT;
        else if (k_sat) state_d = ntc_pkg::ST_FIN;
        else state_d = ntc_pkg::ST_KDIV;
      end
      ntc_pkg::ST_KDIV: if (div_rsp.done) state_d = ntc_pkg::ST_FIN;
      ntc_pkg::ST_FIN:  state_d = ntc_pkg::ST_EMIT;
      ntc_pkg::ST_EMIT: if (out_free) state_d = ntc_pkg::ST_COLLECT;
      default:          state_d = ntc_pkg::ST_COLLECT;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != ntc_pkg::ST_COLLECT);
    ln_start   = (state_q == ntc_pkg::ST_CHECK) && (mean_q != '0) &&
                 (mean_q != ntc_pkg::ADC_FULL);
    div_req.start    = 1'b0;
    div_req.steps    = ntc_pkg::MEAN_STEPS;
    div_req.rem_init = '0;
    div_req.dividend = {sum_q - ntc_pkg::SUM_W'(min_q) - ntc_pkg::SUM_W'(max_q), 7'd0};
    div_req.divisor  = ntc_pkg::DIV_REM_W'(SamplesPerReading - 2);
    case (state_q)
      ntc_pkg::ST_TRIM: div_req.start = 1'b1;
      ntc_pkg::ST_DEN4: begin
        div_req.start    = den_pos && !k_sat;
        div_req.steps    = ntc_pkg::KELVIN_STEPS;
        div_req.rem_init = {11'd0, rem0_q};
        div_req.dividend = '0;
        div_req.divisor  = {2'b00, den_q[39:0]};
      end
      default: ;
    endcase
  end

  ntc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign ln_x[0] = series_eff;
  assign ln_x[1] = ntc_pkg::LN_X_W'(ntc_pkg::ADC_FULL - mean_q);
  assign ln_x[2] = ntc_pkg::LN_X_W'(mean_q);
  assign ln_x[3] = nominal_eff;

  for (genvar g = 0; g < 4; g++) begin : g_ln
    ntc_ln u_ln (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (ln_start),
      .x_i     (ln_x[g]),
      .done_o  (ln_done[g]),
      .ln_o    (ln_res[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ntc_pkg::ST_COLLECT;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) cnt_q <= last_sample ? '0 : cnt_q + 1'b1;
      if (state_q == ntc_pkg::ST_EMIT && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (cnt_q == '0) begin
        sum_q <= ntc_pkg::SUM_W'(adc_sample_i);
        min_q <= adc_sample_i;
        max_q <= adc_sample_i;
      end else begin
        sum_q <= sum_q + ntc_pkg::SUM_W'(adc_sample_i);
        if (adc_sample_i < min_q) min_q <= adc_sample_i;
        if (adc_sample_i > max_q) max_q <= adc_sample_i;
      end
    end
    case (state_q)
      ntc_pkg::ST_MEAN: if (div_rsp.done) mean_q <= div_rsp.quotient[ntc_pkg::ADC_W-1:0];
      ntc_pkg::ST_CHECK: begin
        if (mean_q == '0) begin
          res_temp_q <= '0;
          res_stat_q <= ntc_pkg::STATUS_LOW;
        end else begin
          res_temp_q <= ntc_pkg::TEMP_MAX;
          res_stat_q <= ntc_pkg::STATUS_HIGH;
        end
      end
      ntc_pkg::ST_DEN1: begin
        l_q <= $signed({2'b00, ln_res[0]}) + $signed({2'b00, ln_res[1]})
             - $signed({2'b00, ln_res[2]}) - $signed({2'b00, ln_res[3]});
        bterm_q <= {23'd0, beta_eff} * {16'd0, ntc_pkg::B_SCALE};
      end
      ntc_pkg::ST_DEN2: begin
        lterm_q <= $signed({1'b0, ntc_pkg::T0_CENTI}) * l_q;
        rem0_q  <= {15'd0, beta_eff} * {15'd0, ntc_pkg::T0_CENTI};
      end
      ntc_pkg::ST_DEN3: begin
        den_q <= $signed({2'b00, bterm_q}) + $signed({{3{lterm_q[37]}}, lterm_q});
      end
      ntc_pkg::ST_DEN4: if (k_sat) k_q <= ntc_pkg::KQ8_MAX;
      ntc_pkg::ST_KDIV: if (div_rsp.done) k_q <= div_rsp.quotient;
      ntc_pkg::ST_FIN: begin
        if (cq8[25]) begin
          res_temp_q <= '0;
          res_stat_q <= ntc_pkg::STATUS_LOW;
        end else if (cq8[25:8] > 18'(ntc_pkg::TEMP_MAX)) begin
          res_temp_q <= ntc_pkg::TEMP_MAX;
          res_stat_q <= ntc_pkg::STATUS_HIGH;
        end else begin
          res_temp_q <= cq8[17:8];
          res_stat_q <= ntc_pkg::STATUS_NORMAL;
        end
      end
      ntc_pkg::ST_EMIT: begin
        if (out_free) begin
          temp_q     <= res_temp_q;
          stat_q     <= res_stat_q;
          mean_out_q <= mean_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o     = out_valid_q;
  assign temperature_c_o = temp_q;
  assign mean_adc_o      = mean_out_q;
  assign status_o        = stat_q;

  a_mean_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ntc_pkg::ST_MEAN && div_rsp.done) |->
      div_rsp.quotient[ntc_pkg::DIV_Q_W-1:ntc_pkg::ADC_W] == '0)
    else $error("trimmed mean exceeds ADC range");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(temperature_c_o)))
    else $error("stalled result changed");

  a_temp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> temperature_c_o <= ntc_pkg::TEMP_MAX)
    else $error("temperature above range");

  a_no_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ntc_pkg::ST_LOG || state_q == ntc_pkg::ST_KDIV) |-> !in_acc)
    else $error("sample taken during conversion");

endmodule
